/* rtl/core/fpfa_pkg.sv */
// Shared types and constants for the FIFO page frame allocator.
// Holds the beat structs, the command format between the front and back halves,
// and the configuration register indexes. No dependencies.
package fpfa_pkg;

  // Frame bookkeeping.
  localparam int unsigned NumFrames = 32;
  localparam int unsigned FrameW    = 5;
  localparam int unsigned CountW    = FrameW + 1;

  // Field widths.
  localparam int unsigned SizeW   = 22;
  localparam int unsigned FsW     = 17;
  localparam int unsigned MszW    = 22;
  localparam int unsigned PagesW  = 32;
  localparam int unsigned PctW    = 7;
  localparam int unsigned KindW   = 3;

  // Request rounding divider: quotient bits kept below the overflow limit.
  localparam int unsigned NeedW    = 6;
  localparam int unsigned NeedBitW = $clog2(NeedW);
  localparam int unsigned DivW     = SizeW + 2;

  // Utilization divider.
  localparam int unsigned UsedW    = CountW + FsW;
  localparam int unsigned NumW     = MszW + PctW;
  localparam int unsigned PctBitW  = $clog2(PctW);
  localparam logic [PctW-1:0] PercentFull = 7'd100;

  // Command queue between the two halves.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);

  // Configuration port.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 22;
  localparam logic [CfgIdxW-1:0] CfgFrameSize   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMemorySize  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgFramesInUse = 2'd2;

  typedef enum logic [KindW-1:0] {
    KIND_ALLOCATED      = 3'd0,
    KIND_EVICTED        = 3'd1,
    KIND_FREED          = 3'd2,
    KIND_FREE_REJECTED  = 3'd3,
    KIND_ALLOC_REFUSED  = 3'd4,
    KIND_EMPTY_REQUEST  = 3'd5
  } kind_e;

  typedef struct packed {
    logic              operation;
    logic [SizeW-1:0]  request_size;
    logic [FrameW-1:0] frame_to_free;
  } in_item_t;

  typedef struct packed {
    kind_e             result_kind;
    logic [FrameW-1:0] frame_index;
    logic              last;
    logic [CountW-1:0] free_frames;
    logic [SizeW-1:0]  used_bytes;
    logic [PctW-1:0]   utilization_percent;
    logic [PagesW-1:0] pages_in;
    logic [PagesW-1:0] pages_out;
  } out_item_t;

  // Effective configuration, zero values already replaced.
  typedef struct packed {
    logic [FsW-1:0]    frame_size;
    logic [MszW-1:0]   memory_size;
    logic [CountW-1:0] frames;
  } cfg_t;

  // Classified request handed from the front to the back.
  typedef struct packed {
    logic              is_free;
    logic [FrameW-1:0] frame;
    logic              empty;
    logic              over;
    logic [NeedW-1:0]  need;
  } cmd_t;

endpackage

/* rtl/core/fifo_page_frame_allocator.sv */
// Page frame allocator with FIFO eviction; front divider, command queue, back executor.
// A request is rounded by the front divider and pushed as a command; each result beat
// passes a step, used-bytes and numerator products, a saturation check and the seven
// utilization quotient bits; the back takes no new command until its last beat is out.
// Reset: asynchronous, active low; frame size 16, memory size 512, 32 frames all free.
// Depends on fpfa_pkg, fpfa_front, fpfa_queue and fpfa_back.
module fifo_page_frame_allocator import fpfa_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_data_o
);

  logic [FsW-1:0]    frame_size_q;
  logic [MszW-1:0]   memory_size_q;
  logic [CountW-1:0] frames_q;
  logic [CountW-1:0] frames_wr;
  logic              init;
  cfg_t              cfg;

  logic cmd_valid;
  logic cmd_stall;
  cmd_t cmd;
  logic q_valid;
  logic q_stall;
  cmd_t q_cmd;

  // Effective frame count of a write; zero means one, large values clamp.
  always_comb begin
    frames_wr = cfg_data_i[CountW-1:0];
    if (frames_wr == '0) begin
      frames_wr = CountW'(1);
    end else if (frames_wr > CountW'(NumFrames)) begin
      frames_wr = CountW'(NumFrames);
    end
    init = cfg_we_i && (cfg_index_i == CfgFramesInUse);
    cfg.frame_size  = (frame_size_q == '0) ? FsW'(1) : frame_size_q;
    cfg.memory_size = (memory_size_q == '0) ? MszW'(1) : memory_size_q;
    cfg.frames      = frames_q;
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_size_q  <= FsW'(16);
      memory_size_q <= MszW'(512);
      frames_q      <= CountW'(NumFrames);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgFrameSize:   frame_size_q  <= cfg_data_i[FsW-1:0];
        CfgMemorySize:  memory_size_q <= cfg_data_i[MszW-1:0];
        CfgFramesInUse: frames_q      <= frames_wr;
        default: ;
      endcase
    end
  end

  fpfa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_stall_i (cmd_stall),
    .cmd_o       (cmd)
  );

  fpfa_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (cmd_valid),
    .push_stall_o (cmd_stall),
    .push_data_i  (cmd),
    .pop_valid_o  (q_valid),
    .pop_stall_i  (q_stall),
    .pop_data_o   (q_cmd)
  );

  fpfa_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .init_i        (init),
    .init_frames_i (frames_wr),
    .cmd_valid_i   (q_valid),
    .cmd_stall_o   (q_stall),
    .cmd_i         (q_cmd),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_o    (out_data_o)
  );

endmodule

/* rtl/core/fpfa_front.sv */
// Front half: accepts request beats and rounds allocate sizes up to whole frames.
// Uses a restoring divider, one quotient bit per cycle. Depends on fpfa_pkg.
module fpfa_front import fpfa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_data_i,
  output logic     cmd_valid_o,
  input  logic     cmd_stall_i,
  output cmd_t     cmd_o
);

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} state_e;

  state_e              state_q;
  logic [DivW-1:0]     rem_q;
  logic [NeedW-1:0]    quo_q;
  logic [NeedBitW-1:0] bit_q;
  cmd_t                cmd_q;

  logic [DivW-1:0]  sum;
  logic [DivW-1:0]  over_lim;
  logic [DivW-1:0]  dvs;
  logic             ge;
  logic [NeedW-1:0] quo_d;
  cmd_t             cmd_acc;
  cmd_t             cmd_div;

  // Rounded-up dividend, overflow limit and the trial subtraction.
  always_comb begin
    sum      = DivW'(in_data_i.request_size) + DivW'(cfg_i.frame_size) - DivW'(1);
    over_lim = DivW'(cfg_i.frame_size) << NeedW;
    dvs      = DivW'(cfg_i.frame_size) << bit_q;
    ge       = rem_q >= dvs;
    quo_d    = ge ? (quo_q | (NeedW'(1) << bit_q)) : quo_q;
  end

  // Command of an accepted beat, and the command once the quotient is known.
  always_comb begin
    cmd_acc = '0;
    if (in_data_i.operation) begin
      cmd_acc.is_free = 1'b1;
      cmd_acc.frame   = in_data_i.frame_to_free;
    end else if (sum >= over_lim) begin
      cmd_acc.over = 1'b1;
    end
    cmd_div       = cmd_q;
    cmd_div.need  = quo_d;
    cmd_div.empty = (quo_d == '0);
    cmd_div.over  = (quo_d > cfg_i.frames);
  end

  assign in_stall_o  = (state_q != F_IDLE);
  assign cmd_valid_o = (state_q == F_PUSH);
  assign cmd_o       = cmd_q;

  // Request sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      rem_q   <= '0;
      quo_q   <= '0;
      bit_q   <= '0;
      cmd_q   <= '0;
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (in_valid_i) begin
            cmd_q <= cmd_acc;
            if (cmd_acc.is_free || cmd_acc.over) begin
              state_q <= F_PUSH;
            end else begin
              rem_q   <= sum;
              quo_q   <= '0;
              bit_q   <= NeedBitW'(NeedW - 1);
              state_q <= F_DIV;
            end
          end
        end
        F_DIV: begin
          if (ge) begin
            rem_q <= rem_q - dvs;
          end
          quo_q <= quo_d;
          if (bit_q == '0) begin
            cmd_q   <= cmd_div;
            state_q <= F_PUSH;
          end else begin
            bit_q <= bit_q - NeedBitW'(1);
          end
        end
        F_PUSH: begin
          if (!cmd_stall_i) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/fpfa_queue.sv */
// Short command queue that decouples the front and back halves.
// Depends on fpfa_pkg for the command struct and depth.
module fpfa_queue import fpfa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_stall_o,
  input  cmd_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_stall_i,
  output cmd_t pop_data_o
);

  cmd_t             mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_q;
  logic [QPtrW-1:0] rd_q;
  logic [QPtrW:0]   cnt_q;
  logic             push;
  logic             pop;

  assign push_stall_o = (cnt_q == (QPtrW + 1)'(QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign push         = push_valid_i && !push_stall_o;
  assign pop          = pop_valid_o && !pop_stall_i;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= wr_q + QPtrW'(1);
      end
      if (pop) begin
        rd_q <= rd_q + QPtrW'(1);
      end
      cnt_q <= cnt_q + (QPtrW + 1)'(push) - (QPtrW + 1)'(pop);
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

/* rtl/core/fpfa_back.sv */
// Back half: executes classified commands against the free ring, the age list
// and the allocation map, and produces result beats with utilization. Depends on fpfa_pkg.
module fpfa_back import fpfa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              init_i,
  input  logic [CountW-1:0] init_frames_i,
  input  logic              cmd_valid_i,
  output logic              cmd_stall_o,
  input  cmd_t              cmd_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_data_o
);

  typedef enum logic [2:0] {B_IDLE, B_STEP, B_USED, B_NUM, B_SAT, B_DIV, B_OUT} state_e;

  state_e            state_q;
  cmd_t              cmd_q;
  logic [CountW-1:0] need_q;

  // Free ring, age list (linked by frame) and allocation map.
  logic [FrameW-1:0] ring_q [NumFrames];
  logic [FrameW-1:0] nxt_q  [NumFrames];
  logic [FrameW-1:0] prv_q  [NumFrames];
  logic [FrameW-1:0] fhead_q;
  logic [CountW-1:0] fcount_q;
  logic [FrameW-1:0] ahead_q;
  logic [FrameW-1:0] atail_q;
  logic [CountW-1:0] acount_q;
  logic [NumFrames-1:0] map_q;
  logic [PagesW-1:0] pin_q;
  logic [PagesW-1:0] pout_q;

  // Result assembly and utilization divider.
  out_item_t          rec_q;
  out_item_t          out_q;
  logic               out_valid_q;
  logic [NumW-1:0]    rem_q;
  logic [PctW-1:0]    quo_q;
  logic               sat_q;
  logic [PctBitW-1:0] bit_q;

  logic [FrameW-1:0] pop_frame;
  logic [FrameW-1:0] tail_idx;
  logic [FrameW-1:0] free_frame;
  logic [FrameW-1:0] nxt_rd;
  logic [FrameW-1:0] prv_rd;
  logic              free_ok;
  logic              do_evict;
  logic              step;
  logic              act_evict;
  logic              act_alloc;
  logic              act_free;
  logic              out_free;
  logic [CountW-1:0] fcount_d;
  logic [PagesW-1:0] pin_d;
  logic [PagesW-1:0] pout_d;
  out_item_t         rec_d;
  logic [UsedW-1:0]  used_d;
  logic [NumW-1:0]   num_d;
  logic [NumW-1:0]   lim;
  logic [NumW-1:0]   dvs;
  logic              ge;
  logic [PctW-1:0]   quo_d;
  logic [PctW-1:0]   util;

  // Decide the single action of this step.
  always_comb begin
    pop_frame  = ring_q[fhead_q];
    tail_idx   = fhead_q + FrameW'(fcount_q);
    free_frame = cmd_q.frame;
    nxt_rd     = nxt_q[cmd_q.is_free ? free_frame : ahead_q];
    prv_rd     = prv_q[free_frame];
    free_ok    = (CountW'(free_frame) < cfg_i.frames) && map_q[free_frame];
    do_evict   = !cmd_q.is_free && !cmd_q.empty && (acount_q != '0) &&
                 (cmd_q.over || (fcount_q < need_q));
    step       = (state_q == B_STEP);
    act_free   = step && cmd_q.is_free && free_ok;
    act_evict  = step && do_evict;
    act_alloc  = step && !cmd_q.is_free && !cmd_q.empty && !cmd_q.over && !do_evict;
    out_free   = !out_valid_q || !out_stall_i;
    fcount_d   = fcount_q + CountW'(act_evict || act_free) - CountW'(act_alloc);
    pin_d      = pin_q + PagesW'(act_alloc);
    pout_d     = pout_q + PagesW'(act_free);
  end

  // Result record of this step; used bytes and utilization follow later.
  always_comb begin
    rec_d             = '0;
    rec_d.free_frames = fcount_d;
    rec_d.pages_in    = pin_d;
    rec_d.pages_out   = pout_d;
    rec_d.last        = 1'b1;
    if (cmd_q.is_free) begin
      rec_d.result_kind = free_ok ? KIND_FREED : KIND_FREE_REJECTED;
      rec_d.frame_index = free_frame;
    end else if (cmd_q.empty) begin
      rec_d.result_kind = KIND_EMPTY_REQUEST;
    end else if (do_evict) begin
      rec_d.result_kind = KIND_EVICTED;
      rec_d.frame_index = ahead_q;
      rec_d.last        = 1'b0;
    end else if (cmd_q.over) begin
      rec_d.result_kind = KIND_ALLOC_REFUSED;
    end else begin
      rec_d.result_kind = KIND_ALLOCATED;
      rec_d.frame_index = pop_frame;
      rec_d.last        = (need_q == CountW'(1));
    end
  end

  // Used bytes, its percentage numerator and the trial subtraction.
  always_comb begin
    used_d = UsedW'(cfg_i.frames - fcount_q) * UsedW'(cfg_i.frame_size);
    num_d  = NumW'(rec_q.used_bytes) * NumW'(PercentFull);
    lim    = NumW'(cfg_i.memory_size) << PctW;
    dvs    = NumW'(cfg_i.memory_size) << bit_q;
    ge     = rem_q >= dvs;
    quo_d  = ge ? (quo_q | (PctW'(1) << bit_q)) : quo_q;
    util   = (sat_q || (quo_d > PercentFull)) ? PercentFull : quo_d;
  end

  assign cmd_stall_o = (state_q != B_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Sequencer, list control and the output beat flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      cmd_q       <= '0;
      need_q      <= '0;
      for (int i = 0; i < NumFrames; i++) begin
        ring_q[i] <= FrameW'(i);
      end
      fhead_q     <= '0;
      fcount_q    <= CountW'(NumFrames);
      ahead_q     <= '0;
      atail_q     <= '0;
      acount_q    <= '0;
      map_q       <= '0;
      pin_q       <= '0;
      pout_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // A new beat is loaded when the output register is free.
      if ((state_q == B_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      // Frame count change puts every frame back on the ring in order.
      if (init_i) begin
        for (int i = 0; i < NumFrames; i++) begin
          ring_q[i] <= FrameW'(i);
        end
        fhead_q  <= '0;
        fcount_q <= init_frames_i;
        acount_q <= '0;
        map_q    <= '0;
      end
      unique case (state_q)
        B_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q   <= cmd_i;
            need_q  <= CountW'(cmd_i.need);
            state_q <= B_STEP;
          end
        end
        B_STEP: begin
          fcount_q <= fcount_d;
          pin_q    <= pin_d;
          pout_q   <= pout_d;
          if (act_evict) begin
            ahead_q          <= nxt_rd;
            acount_q         <= acount_q - CountW'(1);
            map_q[ahead_q]   <= 1'b0;
            ring_q[tail_idx] <= ahead_q;
          end
          if (act_free) begin
            if (free_frame == ahead_q) begin
              ahead_q <= nxt_rd;
            end
            if (free_frame == atail_q) begin
              atail_q <= prv_rd;
            end
            acount_q          <= acount_q - CountW'(1);
            map_q[free_frame] <= 1'b0;
            ring_q[tail_idx]  <= free_frame;
          end
          if (act_alloc) begin
            if (acount_q == '0) begin
              ahead_q <= pop_frame;
            end
            atail_q          <= pop_frame;
            acount_q         <= acount_q + CountW'(1);
            map_q[pop_frame] <= 1'b1;
            fhead_q          <= fhead_q + FrameW'(1);
            need_q           <= need_q - CountW'(1);
          end
          state_q <= B_USED;
        end
        B_USED: state_q <= B_NUM;
        B_NUM:  state_q <= B_SAT;
        B_SAT:  state_q <= B_DIV;
        B_DIV: begin
          if (bit_q == '0) begin
            state_q <= B_OUT;
          end
        end
        B_OUT: begin
          if (out_free) begin
            state_q <= rec_q.last ? B_IDLE : B_STEP;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  // Age list links, result record and divider datapath.
  always_ff @(posedge clk_i) begin
    if (act_alloc) begin
      if (acount_q != '0) begin
        nxt_q[atail_q] <= pop_frame;
      end
      prv_q[pop_frame] <= atail_q;
    end
    if (act_free) begin
      if (free_frame != ahead_q) begin
        nxt_q[prv_rd] <= nxt_rd;
      end
      if (free_frame != atail_q) begin
        prv_q[nxt_rd] <= prv_rd;
      end
    end
    unique case (state_q)
      B_STEP: rec_q <= rec_d;
      B_USED: rec_q.used_bytes <= SizeW'(used_d);
      B_NUM:  rem_q <= num_d;
      B_SAT: begin
        sat_q <= (rem_q >= lim);
        quo_q <= '0;
        bit_q <= PctBitW'(PctW - 1);
      end
      B_DIV: begin
        if (ge) begin
          rem_q <= rem_q - dvs;
        end
        quo_q <= quo_d;
        bit_q <= bit_q - PctBitW'(1);
        if (bit_q == '0) begin
          rec_q.utilization_percent <= util;
        end
      end
      B_OUT: begin
        if (out_free) begin
          out_q <= rec_q;
        end
      end
      default: ;
    endcase
  end

endmodule

/* rtl/core/fpfa_checker.sv */
// Port-level checks for the page frame allocator, bound to the top level.
// Depends on fpfa_pkg and fifo_page_frame_allocator.
module fpfa_checker import fpfa_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                cfg_we_i,
  input logic [CfgIdxW-1:0]  cfg_index_i,
  input logic [CfgDataW-1:0] cfg_data_i,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input in_item_t            in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input out_item_t           out_data_o
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat changed");

  // Utilization saturates at full.
  a_util: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.utilization_percent <= PercentFull)
    else $error("utilization above full");

  // After an allocation at least one frame is in use.
  a_alloc_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.result_kind == KIND_ALLOCATED
      |-> out_data_o.free_frames < CountW'(NumFrames) && out_data_o.used_bytes != '0)
    else $error("allocation left no frame in use");

  // Refusals, empty requests and frees (accepted or rejected) close their request.
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.result_kind == KIND_ALLOC_REFUSED ||
                    out_data_o.result_kind == KIND_EMPTY_REQUEST ||
                    out_data_o.result_kind == KIND_FREED ||
                    out_data_o.result_kind == KIND_FREE_REJECTED)
      |-> out_data_o.last)
    else $error("terminal result without last");

endmodule

bind fifo_page_frame_allocator fpfa_checker u_fpfa_checker (.*);
